FILE: rtl/core/pqtt_pkg.sv
// Types and constants shared by the priority queue with time tie-break.
// No dependencies; every other file of the block imports this package.
package pqtt_pkg;

    localparam int TAG_BITS      = 16;
    localparam int PRIORITY_BITS = 8;
    localparam int HOUR_BITS     = 5;
    localparam int MINUTE_BITS   = 6;
    localparam int SECOND_BITS   = 6;
    localparam int TIME_BITS     = HOUR_BITS + MINUTE_BITS + SECOND_BITS;

    localparam logic [0:0] OP_ENQUEUE = 1'b0;
    localparam logic [0:0] OP_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic [0:0]               opcode;
        logic [TAG_BITS-1:0]      process_tag;
        logic [PRIORITY_BITS-1:0] priority_req;
        logic [HOUR_BITS-1:0]     entry_hour;
        logic [MINUTE_BITS-1:0]   entry_minute;
        logic [SECOND_BITS-1:0]   entry_second;
    } t_in_item;

    typedef struct packed {
        logic [1:0]               status;
        logic [TAG_BITS-1:0]      out_tag;
        logic [PRIORITY_BITS-1:0] out_priority;
        logic [HOUR_BITS-1:0]     out_hour;
        logic [MINUTE_BITS-1:0]   out_minute;
        logic [SECOND_BITS-1:0]   out_second;
    } t_out_item;

    typedef struct packed {
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] pri;
        logic [TIME_BITS-1:0]     stamp;  // {hour, minute, second}
    } t_entry;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

FILE: rtl/core/priority_queue_time_tiebreak_unit.sv
// Top level of the sorted priority queue with time tie-break.
// Depends on pqtt_pkg and pqtt_cell.
//
// Usage:
//   Input channel (i_valid, i_item, o_stall) carries one request item:
//   enqueue an entry or dequeue the head. Output channel (o_valid,
//   o_result, i_stall) returns exactly one result item per request:
//   inserted, removed with data, empty, or full and dropped.
//   The store is a row of CAPACITY cells kept sorted, head in cell 0.
//   On enqueue every cell compares its entry with the new one in the
//   same cycle, and the cells at and behind the insert point shift one
//   place back; on dequeue the whole row shifts one place forward.
//   The result is registered and appears in the cycle after the request is taken.
//   Throughput: one item per cycle while the output is not stalled, set by
//   the compare and shift across the whole row of cells at once.
//   Stall: the result register holds while i_stall is high, and o_stall
//   rises in that case so no new request is taken until the result drains.
//   Reset (i_rst_n low, synchronous) empties the queue by clearing the
//   valid bits; the block is ready in the next cycle.
//   An enqueue into a full queue leaves the store unchanged.
module priority_queue_time_tiebreak_unit import pqtt_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_result,
    input  logic      i_stall
);

    logic [CAPACITY-1:0] cell_before;
    logic [CAPACITY-1:0] cell_valid;
    t_entry              cell_entry [CAPACITY];

    t_cell_ctl ctl;
    t_entry    fresh;
    logic      accept;
    logic      full;
    logic      empty;

    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    // Take a new item whenever the result register is free or draining.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign full  = cell_valid[CAPACITY-1];
    assign empty = !cell_valid[0];

    assign fresh.tag   = i_item.process_tag;
    assign fresh.pri   = i_item.priority_req;
    assign fresh.stamp = {i_item.entry_hour, i_item.entry_minute, i_item.entry_second};

    // Drop enqueues on a full row and dequeues on an empty one.
    assign ctl.enq = accept && (i_item.opcode == OP_ENQUEUE) && !full;
    assign ctl.deq = accept && (i_item.opcode == OP_DEQUEUE) && !empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   left_before;
        logic   left_valid;
        t_entry left_entry;
        logic   right_valid;
        t_entry right_entry;

        if (g == 0) begin : g_head
            assign left_before = 1'b0;
            assign left_valid  = 1'b0;
            assign left_entry  = fresh;
        end else begin : g_mid
            assign left_before = cell_before[g-1];
            assign left_valid  = cell_valid[g-1];
            assign left_entry  = cell_entry[g-1];
        end

        if (g == CAPACITY-1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_entry = fresh;
        end else begin : g_body
            assign right_valid = cell_valid[g+1];
            assign right_entry = cell_entry[g+1];
        end

        pqtt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_fresh       (fresh),
            .i_left_before (left_before),
            .i_left_valid  (left_valid),
            .i_left_entry  (left_entry),
            .i_right_valid (right_valid),
            .i_right_entry (right_entry),
            .o_before      (cell_before[g]),
            .o_valid       (cell_valid[g]),
            .o_entry       (cell_entry[g])
        );
    end

    // Build the result; data fields stay zero unless the head is removed.
    always_comb begin
        n_out = '0;
        if (i_item.opcode == OP_ENQUEUE) begin
            n_out.status = full ? ST_FULL : ST_INSERTED;
        end else if (empty) begin
            n_out.status = ST_EMPTY;
        end else begin
            n_out.status       = ST_REMOVED;
            n_out.out_tag      = cell_entry[0].tag;
            n_out.out_priority = cell_entry[0].pri;
            {n_out.out_hour, n_out.out_minute, n_out.out_second} = cell_entry[0].stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: rtl/core/pqtt_cell.sv
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on pqtt_pkg; instantiated in a row by the top level.
module pqtt_cell import pqtt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_fresh,
    input  logic      i_left_before,
    input  logic      i_left_valid,
    input  t_entry    i_left_entry,
    input  logic      i_right_valid,
    input  t_entry    i_right_entry,
    output logic      o_before,
    output logic      o_valid,
    output t_entry    o_entry
);

    logic   r_valid;
    t_entry r_entry;
    logic   n_valid;
    t_entry n_entry;
    logic   goes;

    // New entry stands in front of this one: lower priority here, or same
    // priority with a time not earlier than the new one.
    assign goes = (r_entry.pri < i_fresh.pri) ||
                  ((r_entry.pri == i_fresh.pri) && (r_entry.stamp >= i_fresh.stamp));
    assign o_before = !r_valid || goes;

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (i_ctl.enq && o_before) begin
            if (!i_left_before) begin
                n_valid = 1'b1;
                n_entry = i_fresh;
            end else begin
                n_valid = i_left_valid;
                n_entry = i_left_entry;
            end
        end else if (i_ctl.deq) begin
            n_valid = i_right_valid;
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;

endmodule

FILE: rtl/core/pqtt_checker.sv
// Port-level checks for the priority queue top level, attached by bind.
// Depends on pqtt_pkg and priority_queue_time_tiebreak_unit.
module pqtt_checker import pqtt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input t_in_item  i_item,
    input logic      o_stall,
    input logic      o_valid,
    input t_out_item o_result,
    input logic      i_stall
);

    // Every taken request shows a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("no result after accepted item");

    // Enqueue answers only inserted or full.
    a_enq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_item.opcode == OP_ENQUEUE) |=>
        (o_result.status == ST_INSERTED || o_result.status == ST_FULL))
        else $error("bad status for enqueue");

    // Dequeue answers only removed or empty.
    a_deq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_item.opcode == OP_DEQUEUE) |=>
        (o_result.status == ST_REMOVED || o_result.status == ST_EMPTY))
        else $error("bad status for dequeue");

    // Results without data carry zero fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_REMOVED) |->
        (o_result.out_tag == '0 && o_result.out_priority == '0 &&
         o_result.out_hour == '0 && o_result.out_minute == '0 &&
         o_result.out_second == '0))
        else $error("nonzero data on result without data");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result)))
        else $error("stalled result changed");

endmodule

bind priority_queue_time_tiebreak_unit pqtt_checker u_pqtt_checker (.*);
